>>> sv/plat_pkg.sv
// ----------------------------------------------------------------------------
// plat_pkg: shared definitions for the piecewise-linear access time estimator
// Widths, table geometry, input kind codes and the divider status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package plat_pkg;

  // Table geometry
  localparam int MaxIntervals = 16;
  localparam int IdxW         = $clog2(MaxIntervals);
  localparam int CoefAddrW    = IdxW + 2;

  // Field widths
  localparam int BoundW       = 22;
  localparam int CoefW        = 32;
  localparam int SizeW        = 32;
  localparam int TimeW        = 48;
  localparam int RatioW       = 32;
  localparam int ValW         = 64;

  // Fixed-point layout
  localparam int CoefFracBits  = 8;
  localparam int KbShift       = 10;
  localparam int TimeShift     = KbShift + CoefFracBits;
  localparam int RatioFracBits = 16;
  localparam int StepW         = $clog2(RatioW);

  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [ValW-1:0]   val_t;
  typedef logic [RatioW-1:0] ratio_t;
  typedef logic [TimeW-1:0]  time_t;

  localparam time_t TimeMax = '1;

  // Input item kinds
  localparam logic [1:0] KindQuery = 2'd0;
  localparam logic [1:0] KindBound = 2'd1;
  localparam logic [1:0] KindCoef  = 2'd2;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

>>> sv/plat_ram.sv
// ----------------------------------------------------------------------------
// plat_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module plat_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> sv/plat_div.sv
// ----------------------------------------------------------------------------
// plat_div: serial restoring divider for the Q16.16 time ratio
// One quotient bit per cycle; saturates when the quotient needs more bits.
// ----------------------------------------------------------------------------
`default_nettype none

module plat_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire plat_pkg::val_t    num_i,
  input  wire plat_pkg::val_t    den_i,
  output plat_pkg::div_sts_t     sts_o,
  output plat_pkg::ratio_t       quot_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [plat_pkg::StepW-1:0]       cnt_q, cnt_d;
  plat_pkg::val_t                   rem_q, rem_d;
  plat_pkg::val_t                   den_q, den_d;
  plat_pkg::ratio_t                 qn_q, qn_d;

  plat_pkg::val_t                   rem_init;
  logic [plat_pkg::ValW:0]          rem_sh;
  logic [plat_pkg::ValW:0]          rem_sub;
  logic                             ge;

  // Integer part of the ratio must fit in the integer bits of the result
  assign rem_init = num_i >> (plat_pkg::RatioW - plat_pkg::RatioFracBits);
  assign rem_sh   = {rem_q, qn_q[plat_pkg::RatioW-1]};
  assign rem_sub  = rem_sh - {1'b0, den_q};
  assign ge       = (rem_sh >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    qn_d   = qn_q;
    if (start_i) begin
      den_d = den_i;
      cnt_d = '0;
      if (rem_init >= den_i) begin
        // saturate at once
        qn_d   = '1;
        done_d = 1'b1;
      end else begin
        rem_d  = rem_init;
        qn_d   = plat_pkg::ratio_t'(num_i << plat_pkg::RatioFracBits);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[plat_pkg::ValW-1:0] : rem_sh[plat_pkg::ValW-1:0];
      qn_d  = {qn_q[plat_pkg::RatioW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == plat_pkg::StepW'(plat_pkg::RatioW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    qn_q  <= qn_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quot_o     = qn_q;

endmodule

`default_nettype wire

>>> sv/piecewise_linear_access_time_top.sv
// ----------------------------------------------------------------------------
// piecewise_linear_access_time_top: piecewise-linear access time estimator
// Input channel (in_valid_i / in_ready_o) carries one item per transfer:
//   kind 1 loads an interval upper bound (KB), kind 2 loads a slope or an
//   intercept for one of four access patterns, kind 0 is a query on a size
//   in bytes. Loads are written in the transfer cycle and produce no result;
//   kind 3 is dropped. Each query produces one result on the output channel
//   (out_valid_o / out_ready_i): interval index, sequential time in ns and
//   the random/sequential ratio in Q16.16 with its valid flag.
// cfg_we_i writes interval_count, the number of intervals searched.
// A query runs the bound search over 1..16 bounds, two passes through the
//   shared multiplier and adder, the serial divider (shorter when the ratio
//   saturates at once, skipped when it is not computed) and a hand-off.
//   in_ready_o stays low throughout, so no new item is taken until the
//   query hands off its result.
// The result sits in an output register; a new item is taken while it
//   waits, and a finished query holds in its last step until the register
//   frees up. Reset clears control state and sets interval_count to 1; the
//   tables are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_linear_access_time_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration
  input  wire logic                              cfg_we_i,
  input  wire logic [4:0]                        cfg_wdata_i,
  // input channel
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic [1:0]                        kind_i,
  input  wire logic                              is_read_i,
  input  wire logic [31:0]                       size_bytes_i,
  input  wire logic [3:0]                        entry_i,
  input  wire logic                              random_pattern_i,
  input  wire logic                              coef_is_intercept_i,
  input  wire logic signed [31:0]                load_value_i,
  // output channel
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [3:0]                             interval_index_o,
  output logic [47:0]                            access_time_ns_o,
  output logic [31:0]                            ratio_q16_o,
  output logic                                   ratio_valid_o
);

  // Sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_MUL_S = 3'd2;
  localparam logic [2:0] S_MUL_R = 3'd3;
  localparam logic [2:0] S_SUM_R = 3'd4;
  localparam logic [2:0] S_EVAL  = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]                         state_q, state_d;
  logic [4:0]                         count_q;
  plat_pkg::idx_t                     idx_q, idx_d;
  plat_pkg::idx_t                     sel_q, sel_d;
  plat_pkg::idx_t                     last_idx;
  logic [plat_pkg::SizeW-1:0]         size_q, size_d;
  logic                               rd_q, rd_d;

  logic signed [plat_pkg::ValW:0]     prod_q, prod_d;
  logic signed [plat_pkg::CoefW-1:0]  icpt_q, icpt_d;
  logic signed [plat_pkg::ValW:0]     vs_q, vs_d;
  logic signed [plat_pkg::ValW:0]     vr_q, vr_d;
  logic signed [plat_pkg::ValW:0]     line_sum;
  logic signed [plat_pkg::ValW:0]     icpt_x;
  logic signed [plat_pkg::SizeW:0]    size_s;
  logic signed [plat_pkg::CoefW-1:0]  slope_s;

  logic                               ps, pr;
  plat_pkg::val_t                     t_full;
  plat_pkg::time_t                    t_sat;

  plat_pkg::time_t                    time_q, time_d;
  logic                               pv_q, pv_d;
  plat_pkg::ratio_t                   ratio_q, ratio_d;

  logic                               out_valid_q, out_valid_d;
  plat_pkg::idx_t                     oidx_q, oidx_d;
  plat_pkg::time_t                    otime_q, otime_d;
  plat_pkg::ratio_t                   oratio_q, oratio_d;
  logic                               opv_q, opv_d;

  logic                               in_xfer;
  logic                               entry_ok;
  logic                               bound_we, coef_we;
  logic                               slope_we, icpt_we;
  logic [plat_pkg::CoefAddrW-1:0]     coef_waddr, coef_raddr;
  logic [plat_pkg::BoundW-1:0]        bound_rdata;
  logic [plat_pkg::CoefW-1:0]         slope_rdata, icpt_rdata;
  logic                               hit;
  logic                               div_start;
  plat_pkg::div_sts_t                 div_sts;
  plat_pkg::ratio_t                   div_quot;
  logic                               out_free;

  // --------------------------------------------------------------------------
  // Load path: tables are written in the transfer cycle
  // --------------------------------------------------------------------------
  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign entry_ok   = (32'(entry_i) < 32'(plat_pkg::MaxIntervals));
  assign bound_we   = in_xfer && (kind_i == plat_pkg::KindBound) && entry_ok;
  assign coef_we    = in_xfer && (kind_i == plat_pkg::KindCoef) && entry_ok;
  assign slope_we   = coef_we && !coef_is_intercept_i;
  assign icpt_we    = coef_we && coef_is_intercept_i;
  assign coef_waddr = {plat_pkg::idx_t'(entry_i), is_read_i, random_pattern_i};

  // Sequential pattern during the search, random pattern right after it
  assign coef_raddr = (state_q == S_SRCH) ? {idx_q, rd_q, 1'b0} : {sel_q, rd_q, 1'b1};

  plat_ram #(
    .Width (plat_pkg::BoundW),
    .Depth (plat_pkg::MaxIntervals)
  ) u_bound_ram (
    .clk_i   (clk_i),
    .we_i    (bound_we),
    .waddr_i (plat_pkg::idx_t'(entry_i)),
    .wdata_i (load_value_i[plat_pkg::BoundW-1:0]),
    .raddr_i (idx_d),
    .rdata_o (bound_rdata)
  );

  plat_ram #(
    .Width (plat_pkg::CoefW),
    .Depth (4 * plat_pkg::MaxIntervals)
  ) u_slope_ram (
    .clk_i   (clk_i),
    .we_i    (slope_we),
    .waddr_i (coef_waddr),
    .wdata_i (load_value_i),
    .raddr_i (coef_raddr),
    .rdata_o (slope_rdata)
  );

  plat_ram #(
    .Width (plat_pkg::CoefW),
    .Depth (4 * plat_pkg::MaxIntervals)
  ) u_icpt_ram (
    .clk_i   (clk_i),
    .we_i    (icpt_we),
    .waddr_i (coef_waddr),
    .wdata_i (load_value_i),
    .raddr_i (coef_raddr),
    .rdata_o (icpt_rdata)
  );

  // --------------------------------------------------------------------------
  // Shared arithmetic: one multiplier and one adder, used once per pattern
  // --------------------------------------------------------------------------
  always_comb begin
    if (count_q == '0) begin
      last_idx = '0;
    end else if (32'(count_q) > 32'(plat_pkg::MaxIntervals)) begin
      last_idx = plat_pkg::idx_t'(plat_pkg::MaxIntervals - 1);
    end else begin
      last_idx = plat_pkg::idx_t'(count_q - 5'd1);
    end
  end

  // size <= bound * 1024
  assign hit = (size_q <= {bound_rdata, 10'd0}) || (idx_q == last_idx);

  assign slope_s  = slope_rdata;
  assign size_s   = {1'b0, size_q};
  assign prod_d   = slope_s * size_s;
  assign icpt_x   = {{(plat_pkg::ValW + 1 - plat_pkg::CoefW - plat_pkg::KbShift){icpt_q[31]}},
                     icpt_q, {plat_pkg::KbShift{1'b0}}};
  assign line_sum = prod_q + icpt_x;

  // exact value is positive: non-negative and not zero
  assign ps = !vs_q[plat_pkg::ValW] && (vs_q != '0);
  assign pr = !vr_q[plat_pkg::ValW] && (vr_q != '0);

  assign t_full = vs_q[plat_pkg::ValW-1:0] >> plat_pkg::TimeShift;
  assign t_sat  = (t_full > plat_pkg::val_t'(plat_pkg::TimeMax)) ?
                  plat_pkg::TimeMax : plat_pkg::time_t'(t_full);

  assign div_start = (state_q == S_EVAL) && ps && pr;

  plat_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (vr_q[plat_pkg::ValW-1:0]),
    .den_i   (vs_q[plat_pkg::ValW-1:0]),
    .sts_o   (div_sts),
    .quot_o  (div_quot)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    sel_d       = sel_q;
    size_d      = size_q;
    rd_d        = rd_q;
    icpt_d      = icpt_q;
    vs_d        = vs_q;
    vr_d        = vr_q;
    time_d      = time_q;
    pv_d        = pv_q;
    ratio_d     = ratio_q;
    out_valid_d = out_valid_q && !out_ready_i;
    oidx_d      = oidx_q;
    otime_d     = otime_q;
    oratio_d    = oratio_q;
    opv_d       = opv_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer && (kind_i == plat_pkg::KindQuery)) begin
          // start reading the first bound now
          idx_d   = '0;
          size_d  = size_bytes_i;
          rd_d    = is_read_i;
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (hit) begin
          sel_d   = idx_q;
          state_d = S_MUL_S;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_MUL_S: begin
        icpt_d  = icpt_rdata;
        state_d = S_MUL_R;
      end
      S_MUL_R: begin
        vs_d    = line_sum;
        icpt_d  = icpt_rdata;
        state_d = S_SUM_R;
      end
      S_SUM_R: begin
        vr_d    = line_sum;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        pv_d    = ps;
        time_d  = ps ? t_sat : '0;
        ratio_d = '0;
        state_d = (ps && pr) ? S_DIV : S_DONE;
      end
      S_DIV: begin
        if (div_sts.done) begin
          ratio_d = div_quot;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          oidx_d      = sel_q;
          otime_d     = time_q;
          oratio_d    = ratio_q;
          opv_d       = pv_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= 5'd1;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q    <= sel_d;
    size_q   <= size_d;
    rd_q     <= rd_d;
    prod_q   <= prod_d;
    icpt_q   <= icpt_d;
    vs_q     <= vs_d;
    vr_q     <= vr_d;
    time_q   <= time_d;
    pv_q     <= pv_d;
    ratio_q  <= ratio_d;
    oidx_q   <= oidx_d;
    otime_q  <= otime_d;
    oratio_q <= oratio_d;
    opv_q    <= opv_d;
  end

  assign out_valid_o      = out_valid_q;
  assign interval_index_o = 4'(oidx_q);
  assign access_time_ns_o = otime_q;
  assign ratio_q16_o      = oratio_q;
  assign ratio_valid_o    = opv_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_ratio_zero_when_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ratio_valid_o |-> ratio_q16_o == '0)
    else $error("ratio nonzero while flagged invalid");

  a_time_zero_when_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ratio_valid_o |-> access_time_ns_o == '0)
    else $error("access time nonzero for non-positive sequential time");

  a_div_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> div_sts.busy || div_sts.done)
    else $error("waiting on an idle divider");

  a_query_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && kind_i == plat_pkg::KindQuery |=> !in_ready_o)
    else $error("input taken while a query is in progress");

endmodule

`default_nettype wire
